// File: rtl/hmts_pkg.sv
// hmts_pkg: shared types, constants and register codes of the heightmap triangle sampler
`timescale 1ns / 1ps

package hmts_pkg;

  // grid storage
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 128;
  localparam int GRID_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int ADDR_W = $clog2(GRID_DEPTH);

  // field widths
  localparam int HEIGHT_W = 16;
  localparam int POINT_W = 24;
  localparam int RECIP_W = 16;
  localparam int COUNT_W = 8;
  localparam int GRID_W = POINT_W + RECIP_W + 1;
  localparam int FRAC_W = 16;
  localparam int CELL_W = GRID_W - FRAC_W;
  localparam int WEIGHT_W = 9;
  localparam int PROD_W = HEIGHT_W + WEIGHT_W + 1;
  localparam int ACC_W = PROD_W;

  // fallback height when the point is off the grid (-1.0)
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_OUTSIDE = -16'sd256;

  // item operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_INV_CELL_WIDTH = 2'd0;
  localparam logic [1:0] REG_INV_CELL_DEPTH = 2'd1;
  localparam logic [1:0] REG_COLS_IN_USE = 2'd2;
  localparam logic [1:0] REG_ROWS_IN_USE = 2'd3;

  // corner of the chosen triangle
  typedef enum logic [1:0] {
    CORNER_BASE = 2'd0,
    CORNER_MID  = 2'd1,
    CORNER_FAR  = 2'd2
  } corner_t;

  typedef struct packed {
    logic                       operation;
    logic [6:0]                 column;
    logic [6:0]                 row;
    logic signed [HEIGHT_W-1:0] height_value;
    logic signed [POINT_W-1:0]  point_x;
    logic signed [POINT_W-1:0]  point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic                       outside;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    mul;
    logic    check;
    corner_t rd_sel;
    logic    mac;
    corner_t mac_sel;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sample;
    logic outside;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/hmts_ram.sv
// hmts_ram: generic single-port RAM with registered read
`timescale 1ns / 1ps

module hmts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/hmts_ctrl.sv
// hmts_ctrl: sequencing state machine of the heightmap triangle sampler
`timescale 1ns / 1ps

module hmts_ctrl import hmts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_RD0   = 8'b0000_1000,
    S_RD1   = 8'b0001_0000,
    S_RD2   = 8'b0010_0000,
    S_MAC   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rd_sel = CORNER_BASE;
    cmd.mac_sel = CORNER_BASE;
    unique case (state)
      S_IDLE: begin
        cmd.capture = accept;
        if (accept && stat.is_sample) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_next = stat.outside ? S_DONE : S_RD0;
      end
      S_RD0: begin
        cmd.rd_sel = CORNER_BASE;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_sel = CORNER_MID;
        cmd.mac = 1'b1;
        cmd.mac_sel = CORNER_BASE;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_sel = CORNER_FAR;
        cmd.mac = 1'b1;
        cmd.mac_sel = CORNER_MID;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        cmd.mac_sel = CORNER_FAR;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/hmts_dp.sv
// hmts_dp: grid memory, coordinate scaling and barycentric blend datapath
`timescale 1ns / 1ps

module hmts_dp import hmts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  in_item_t           in_data,
  input  logic [RECIP_W-1:0] inv_cell_width,
  input  logic [RECIP_W-1:0] inv_cell_depth,
  input  logic [COUNT_W-1:0] cols_in_use,
  input  logic [COUNT_W-1:0] rows_in_use,
  output out_item_t          out_data,
  output logic               out_valid,
  input  logic               out_stall
);

  logic signed [POINT_W-1:0]  px;
  logic signed [POINT_W-1:0]  py;
  logic signed [GRID_W-1:0]   gx;
  logic signed [GRID_W-1:0]   gy;
  logic [CELL_W-1:0]          cx;
  logic [CELL_W-1:0]          cy;
  logic [CELL_W-1:0]          cx_p1;
  logic [CELL_W-1:0]          cy_p1;
  logic [CELL_W-1:0]          cols_eff;
  logic [CELL_W-1:0]          rows_eff;
  logic [7:0]                 lx;
  logic [7:0]                 ly;
  logic                       upper;
  logic                       outside_now;
  logic [COL_W-1:0]           col_q;
  logic [ROW_W-1:0]           row_q;
  logic [COL_W-1:0]           col_p1;
  logic [ROW_W-1:0]           row_p1;
  logic                       upper_q;
  logic                       outside_q;
  logic [WEIGHT_W-1:0]        w0;
  logic [WEIGHT_W-1:0]        w1;
  logic [WEIGHT_W-1:0]        w2;
  logic [WEIGHT_W-1:0]        w_sel;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_round;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          ram_addr;
  logic                       ram_we;
  logic [HEIGHT_W-1:0]        ram_rdata;

  // grid memory: writes at acceptance, corner reads while sampling
  assign wr_addr = ADDR_W'(in_data.row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_data.column);
  assign ram_we = cmd.capture && (in_data.operation == OP_WRITE)
                  && (int'(in_data.column) < MAX_COLS) && (int'(in_data.row) < MAX_ROWS);
  assign ram_addr = ram_we ? wr_addr : rd_addr;

  hmts_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(GRID_DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_data.height_value),
    .rdata(ram_rdata)
  );

  // point capture and scaling to grid coordinates
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px <= in_data.point_x;
      py <= in_data.point_y;
    end
    if (cmd.mul) begin
      gx <= GRID_W'(px) * GRID_W'($signed({1'b0, inv_cell_width}));
      gy <= GRID_W'(py) * GRID_W'($signed({1'b0, inv_cell_depth}));
    end
  end

  // cell, local position and off-grid test
  assign cx = gx[GRID_W-1:FRAC_W];
  assign cy = gy[GRID_W-1:FRAC_W];
  assign lx = gx[FRAC_W-1:FRAC_W-8];
  assign ly = gy[FRAC_W-1:FRAC_W-8];
  assign cx_p1 = cx + CELL_W'(1);
  assign cy_p1 = cy + CELL_W'(1);
  assign cols_eff = (CELL_W'(cols_in_use) > CELL_W'(MAX_COLS)) ? CELL_W'(MAX_COLS)
                                                               : CELL_W'(cols_in_use);
  assign rows_eff = (CELL_W'(rows_in_use) > CELL_W'(MAX_ROWS)) ? CELL_W'(MAX_ROWS)
                                                               : CELL_W'(rows_in_use);
  assign outside_now = cx[CELL_W-1] || cy[CELL_W-1]
                       || (cx_p1 >= cols_eff) || (cy_p1 >= rows_eff);
  assign upper = (ly > lx);

  // triangle selection and weights
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      col_q <= cx[COL_W-1:0];
      row_q <= cy[ROW_W-1:0];
      upper_q <= upper;
      outside_q <= outside_now;
      if (upper) begin
        w0 <= WEIGHT_W'(256) - WEIGHT_W'(ly);
        w1 <= WEIGHT_W'(ly - lx);
        w2 <= WEIGHT_W'(lx);
      end else begin
        w0 <= WEIGHT_W'(256) - WEIGHT_W'(lx);
        w1 <= WEIGHT_W'(ly);
        w2 <= WEIGHT_W'(lx - ly);
      end
    end
  end

  // corner addresses: upper triangle takes (c,r+1), lower takes (c+1,r)
  assign col_p1 = col_q + COL_W'(1);
  assign row_p1 = row_q + ROW_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      CORNER_MID: begin
        rd_addr = upper_q
          ? ADDR_W'(row_p1) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q)
          : ADDR_W'(row_p1) * ADDR_W'(MAX_COLS) + ADDR_W'(col_p1);
      end
      CORNER_FAR: begin
        rd_addr = upper_q
          ? ADDR_W'(row_p1) * ADDR_W'(MAX_COLS) + ADDR_W'(col_p1)
          : ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_p1);
      end
      default: begin
        rd_addr = ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);
      end
    endcase
  end

  // weighted accumulation of the three corner heights
  always_comb begin
    case (cmd.mac_sel)
      CORNER_MID: w_sel = w1;
      CORNER_FAR: w_sel = w2;
      default:    w_sel = w0;
    endcase
  end

  assign prod = PROD_W'($signed(ram_rdata)) * PROD_W'($signed({1'b0, w_sel}));

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      acc <= '0;
    end else if (cmd.mac) begin
      acc <= acc + prod;
    end
  end

  // round half up, then divide by 256
  assign acc_round = acc + ACC_W'(128);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.outside <= outside_q;
      out_data.height <= outside_q ? HEIGHT_OUTSIDE : acc_round[HEIGHT_W+7:8];
    end
  end

  // status back to the controller
  always_comb begin
    stat.is_sample = (in_data.operation == OP_SAMPLE);
    stat.outside = outside_now;
    stat.out_free = !out_valid || !out_stall;
  end

endmodule

// File: rtl/heightmap_triangle_sampler.sv
// heightmap_triangle_sampler: top level with configuration registers, controller and datapath
`timescale 1ns / 1ps

// Keeps a 128 x 128 grid of signed Q8.8 heights in one single-port memory.
// A write transaction stores one height at acceptance and leaves the block
// idle; it returns nothing. A sample transaction scales the Q16.8 point by the
// reciprocal cell sizes, checks the cell against cols_in_use and rows_in_use,
// and returns either -1.0 with outside set or the barycentric blend of three
// corners of the cell. From acceptance to the result register a sample passes
// through capture, the scaling multipliers and the cell test; then the three
// corner heights are read one after another through the single memory port
// and accumulated by one multiply-add unit that takes each height in the cycle
// after its read, and the result is loaded. A point off the grid goes from the
// cell test straight to the load. The next transaction is taken once the result
// sits in the output register, which can hold it while the receiver stalls. The
// grid is not cleared at reset: sample only cells whose corners were written.
// Registers (APB, byte address 4*i): inv_cell_width, inv_cell_depth,
// cols_in_use, rows_in_use.

module heightmap_triangle_sampler import hmts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [RECIP_W-1:0] inv_cell_width;
  logic [RECIP_W-1:0] inv_cell_depth;
  logic [COUNT_W-1:0] cols_in_use;
  logic [COUNT_W-1:0] rows_in_use;
  logic [1:0]         reg_idx;
  logic               cfg_write;
  cmd_t               cmd;
  stat_t              stat;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell_width <= RECIP_W'(256);
      inv_cell_depth <= RECIP_W'(256);
      cols_in_use <= COUNT_W'(128);
      rows_in_use <= COUNT_W'(128);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_INV_CELL_WIDTH: inv_cell_width <= pwdata[RECIP_W-1:0];
        REG_INV_CELL_DEPTH: inv_cell_depth <= pwdata[RECIP_W-1:0];
        REG_COLS_IN_USE:    cols_in_use <= pwdata[COUNT_W-1:0];
        REG_ROWS_IN_USE:    rows_in_use <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_INV_CELL_WIDTH: prdata = 32'(inv_cell_width);
      REG_INV_CELL_DEPTH: prdata = 32'(inv_cell_depth);
      REG_COLS_IN_USE:    prdata = 32'(cols_in_use);
      REG_ROWS_IN_USE:    prdata = 32'(rows_in_use);
      default:            prdata = '0;
    endcase
  end

  hmts_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  hmts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_data       (in_data),
    .inv_cell_width(inv_cell_width),
    .inv_cell_depth(inv_cell_depth),
    .cols_in_use   (cols_in_use),
    .rows_in_use   (rows_in_use),
    .out_data      (out_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule
